@@ src/cgut_pkg.sv @@
// Shared types, constants and helpers for the crowd update throttle.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cgut_pkg;

    // Slot table depth default and hash constant
    localparam int unsigned SLOT_ENTRIES_DEF = 8192;
    localparam logic [31:0] HASH_MULT        = 32'h7feb_352d;

    // Valid pointer window
    localparam logic [31:0] ADDR_LO = 32'h0001_0000;
    localparam logic [31:0] ADDR_HI = 32'hFFE0_0000;

    // Width of the serial remainder dividend
    localparam int unsigned DVD_W = 32;

    // Register reset values
    localparam logic [15:0] ENGAGE_RST    = 16'd30;
    localparam logic [15:0] DISENGAGE_RST = 16'd22;
    localparam logic [15:0] GAP_RST       = 16'd500;
    localparam logic [15:0] BUSY_RST      = 16'd80;
    localparam logic [15:0] DENSE_RST     = 16'd160;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ENGAGE    = 3'd0,
        CFG_DISENGAGE = 3'd1,
        CFG_GAP       = 3'd2,
        CFG_BUSY      = 3'd3,
        CFG_DENSE     = 3'd4
    } t_cfg_idx;

    // Decision codes
    typedef enum logic [1:0] {
        DEC_REJECT   = 2'd0,
        DEC_FULL     = 2'd1,
        DEC_THROTTLE = 2'd2
    } t_decision;

    // Slot table write port
    typedef struct packed {
        logic        key_we;
        logic [31:0] key;
        logic        tick_we;
        logic [31:0] tick;
    } t_slot_wr;

    // Pointer range check
    function automatic logic addr_ok(input logic [31:0] a);
        addr_ok = (a >= ADDR_LO) && (a < ADDR_HI);
    endfunction

endpackage

`default_nettype wire

@@ src/cgut_hash.sv @@
// Two-stage integer mixing hash: xor-shift, constant multiply, xor-shift.
// Uses cgut_pkg for the multiplier constant.
`timescale 1ns / 1ps
`default_nettype none

module cgut_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_x,
    output logic             o_done,
    output logic [31:0]      o_h
);

    logic        r_v1;
    logic        r_v2;
    logic [31:0] r_x1;
    logic [31:0] r_p;
    logic [31:0] w_prod;

    // low word of the product only
    assign w_prod = r_x1 * cgut_pkg::HASH_MULT;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        r_x1 <= i_x ^ (i_x >> 16);
        r_p  <= w_prod;
    end

    assign o_done = r_v2;
    assign o_h    = r_p ^ (r_p >> 15);

endmodule

`default_nettype wire

@@ src/cgut_rem.sv @@
// Serial restoring remainder unit, one dividend bit per cycle.
// Uses cgut_pkg for the dividend width; shared by slot and phase reductions.
`timescale 1ns / 1ps
`default_nettype none

module cgut_rem #(
    parameter int unsigned DIV_W = 14
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [cgut_pkg::DVD_W-1:0]  i_dividend,
    input  wire logic [DIV_W-1:0]            i_divisor,
    output logic                             o_done,
    output logic [DIV_W-1:0]                 o_rem
);

    localparam int unsigned CNT_W = $clog2(cgut_pkg::DVD_W);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [cgut_pkg::DVD_W-1:0] r_q;
    logic [DIV_W-1:0]           r_rem;
    logic [DIV_W-1:0]           r_div;
    logic [DIV_W:0]             w_trial;
    logic [DIV_W:0]             w_sub;
    logic [DIV_W-1:0]           n_rem;

    // shift in next bit, subtract when it fits
    assign w_trial = {r_rem, r_q[cgut_pkg::DVD_W-1]};
    assign w_sub   = w_trial - {1'b0, r_div};
    assign n_rem   = (w_trial >= {1'b0, r_div}) ? w_sub[DIV_W-1:0] : w_trial[DIV_W-1:0];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(cgut_pkg::DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[cgut_pkg::DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

@@ src/cgut_slot_ram.sv @@
// Slot table: key and tick arrays on one address, registered read.
// Uses cgut_pkg for the write port struct.
`timescale 1ns / 1ps
`default_nettype none

module cgut_slot_ram #(
    parameter int unsigned DEPTH = 8192,
    parameter int unsigned AW    = 13
) (
    input  wire logic               i_clk,
    input  wire logic [AW-1:0]      i_addr,
    input  wire cgut_pkg::t_slot_wr i_wr,
    output logic [31:0]             o_key,
    output logic [31:0]             o_tick
);

    logic [31:0] mem_key  [DEPTH];
    logic [31:0] mem_tick [DEPTH];
    logic [31:0] r_key;
    logic [31:0] r_tick;

    // key array
    always_ff @(posedge i_clk) begin
        if (i_wr.key_we) begin
            mem_key[i_addr] <= i_wr.key;
        end
        r_key <= mem_key[i_addr];
    end

    // tick array, written only by real slot updates
    always_ff @(posedge i_clk) begin
        if (i_wr.tick_we) begin
            mem_tick[i_addr] <= i_wr.tick;
        end
        r_tick <= mem_tick[i_addr];
    end

    assign o_key  = r_key;
    assign o_tick = r_tick;

endmodule

`default_nettype wire

@@ src/crowd_graduated_update_throttle.sv @@
// Top level of the crowd update throttle: sequencer, frame state, config.
// Uses cgut_pkg, cgut_hash, cgut_rem and cgut_slot_ram.
//
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------------
//  request   | start, busy          | i_model_address .. i_time_ms
//  result    | o_valid (1 cycle)    | o_decision, o_crowd_engaged, o_frame_crowd,
//            |                      | o_throttle_interval
//  config    | i_cfg_we             | i_cfg_index, i_cfg_data
//
// A request is taken when start is high and busy low; busy stays high until its
// result strobe. Rejected, guarded or uncrowded requests end in the evaluation
// state; a hit on a known slot passes two hash stages and one slot read; claiming
// a new slot hashes again and runs the 32-step serial remainder for the phase.
// With a non power of two table depth each slot reduction runs that remainder too.
// After reset every slot key is swept to zero while busy is high.
// Results cannot be stalled: each is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module crowd_graduated_update_throttle #(
    parameter int unsigned SLOT_ENTRIES = cgut_pkg::SLOT_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_model_address,
    input  wire logic        i_on_main_thread,
    input  wire logic        i_model_active,
    input  wire logic        i_update_requested,
    input  wire logic [31:0] i_parent_address,
    input  wire logic        i_is_protected,
    input  wire logic [31:0] i_context_address,
    input  wire logic [31:0] i_anim_tick,
    input  wire logic [31:0] i_model_last_tick,
    input  wire logic [31:0] i_time_ms,
    // result
    output logic             o_valid,
    output logic [1:0]       o_decision,
    output logic             o_crowd_engaged,
    output logic [15:0]      o_frame_crowd,
    output logic [2:0]       o_throttle_interval,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int unsigned IDX_W     = $clog2(SLOT_ENTRIES);
    localparam int unsigned DIV_W     = $clog2(SLOT_ENTRIES + 1);
    localparam bit          SLOT_POW2 = ((SLOT_ENTRIES & (SLOT_ENTRIES - 1)) == 0);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_EVAL   = 10'b00_0000_0100,
        S_HASH_A = 10'b00_0000_1000,
        S_MOD_A  = 10'b00_0001_0000,
        S_READ   = 10'b00_0010_0000,
        S_CMP    = 10'b00_0100_0000,
        S_HASH_B = 10'b00_1000_0000,
        S_MOD_B  = 10'b01_0000_0000,
        S_PHASE  = 10'b10_0000_0000
    } t_state;

    // interval for a crowd size, dense level first
    function automatic logic [2:0] iv_for(input logic [15:0] n, input logic [15:0] dense,
                                          input logic [15:0] busy_lvl);
        if (n >= dense) begin
            iv_for = 3'd4;
        end else if (n >= busy_lvl) begin
            iv_for = 3'd3;
        end else begin
            iv_for = 3'd2;
        end
    endfunction

    // configuration registers
    logic [15:0] r_cfg_engage;
    logic [15:0] r_cfg_disengage;
    logic [15:0] r_cfg_gap;
    logic [15:0] r_cfg_busy;
    logic [15:0] r_cfg_dense;

    // latched request
    logic [31:0] r_addr;
    logic        r_on_main;
    logic        r_active;
    logic        r_upd;
    logic [31:0] r_parent;
    logic        r_prot;
    logic [31:0] r_ctx;
    logic [31:0] r_tick;
    logic [31:0] r_last;
    logic [31:0] r_now;

    // frame state
    logic [15:0] r_frame_count,  n_frame_count;
    logic [15:0] r_lfc,          n_lfc;
    logic [31:0] r_frame_tick,   n_frame_tick;
    logic [31:0] r_ref_ctx,      n_ref_ctx;
    logic [31:0] r_last_roll,    n_last_roll;
    logic        r_crowded,      n_crowded;

    // sequencer
    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_clr,   n_clr;
    logic [IDX_W-1:0]       r_idx,   n_idx;
    logic                   r_valid, n_valid;
    cgut_pkg::t_decision    r_decision, n_decision;

    // evaluation terms
    logic        w_accept;
    logic        w_guard_ok;
    logic [31:0] w_elapsed;
    logic        w_relatch;
    logic [31:0] w_ref_new;
    logic        w_roll;
    logic        w_crowd_new;
    logic [2:0]  w_iv;
    logic [31:0] w_age;

    // shared units
    logic                   w_hash_start;
    logic [31:0]            w_hash_x;
    logic                   w_hash_done;
    logic [31:0]            w_hash_h;
    logic                   w_rem_start;
    logic [31:0]            w_rem_dvd;
    logic [DIV_W-1:0]       w_rem_div;
    logic                   w_rem_done;
    logic [DIV_W-1:0]       w_rem_out;
    logic [IDX_W-1:0]       w_ram_addr;
    cgut_pkg::t_slot_wr     w_wr;
    logic [31:0]            w_ram_key;
    logic [31:0]            w_ram_tick;

    assign w_accept = start && !busy;

    // guards and frame roll
    assign w_guard_ok = r_on_main && r_active && !r_upd && !cgut_pkg::addr_ok(r_parent)
                        && !r_prot && cgut_pkg::addr_ok(r_ctx) && (r_last != 32'd0);
    assign w_elapsed  = r_now - r_last_roll;
    assign w_relatch  = (r_ref_ctx == 32'd0) || (w_elapsed > {16'd0, r_cfg_gap});
    assign w_ref_new  = w_relatch ? r_ctx : r_ref_ctx;
    assign w_roll     = (r_ctx == w_ref_new) && (r_tick != r_frame_tick);
    assign w_crowd_new = w_roll ? (r_crowded ? (r_frame_count >= r_cfg_disengage)
                                             : (r_frame_count >= r_cfg_engage))
                                : r_crowded;
    assign w_iv       = iv_for(r_lfc, r_cfg_dense, r_cfg_busy);
    assign w_age      = r_tick - w_ram_tick;

    // sequencer and state update
    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_idx         = r_idx;
        n_valid       = 1'b0;
        n_decision    = r_decision;
        n_frame_count = r_frame_count;
        n_lfc         = r_lfc;
        n_frame_tick  = r_frame_tick;
        n_ref_ctx     = r_ref_ctx;
        n_last_roll   = r_last_roll;
        n_crowded     = r_crowded;
        w_hash_start  = 1'b0;
        w_hash_x      = r_addr;
        w_rem_start   = 1'b0;
        w_rem_dvd     = w_hash_h;
        w_rem_div     = DIV_W'(SLOT_ENTRIES);
        w_wr          = '0;

        unique case (r_state)
            // zero every key once after reset
            S_CLEAR: begin
                w_wr.key_we = 1'b1;
                n_clr       = r_clr + 1'b1;
                if (r_clr == IDX_W'(SLOT_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EVAL;
                end
            end
            // guards, relatch, roll and count
            S_EVAL: begin
                if (!cgut_pkg::addr_ok(r_addr)) begin
                    n_decision = cgut_pkg::DEC_REJECT;
                    n_valid    = 1'b1;
                    n_state    = S_IDLE;
                end else if (!w_guard_ok) begin
                    n_decision = cgut_pkg::DEC_FULL;
                    n_valid    = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_ref_ctx   = w_ref_new;
                    n_last_roll = (w_relatch || w_roll) ? r_now : r_last_roll;
                    n_crowded   = w_crowd_new;
                    if (w_roll) begin
                        n_lfc         = r_frame_count;
                        n_frame_tick  = r_tick;
                        n_frame_count = 16'd1;
                    end else if (r_frame_count != 16'hFFFF) begin
                        n_frame_count = r_frame_count + 16'd1;
                    end
                    if ((r_tick == r_last) || !w_crowd_new) begin
                        n_decision = cgut_pkg::DEC_FULL;
                        n_valid    = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        w_hash_start = 1'b1;
                        n_state      = S_HASH_A;
                    end
                end
            end
            // slot index of the model
            S_HASH_A: begin
                if (w_hash_done) begin
                    if (SLOT_POW2) begin
                        n_idx   = w_hash_h[IDX_W-1:0];
                        n_state = S_READ;
                    end else begin
                        w_rem_start = 1'b1;
                        n_state     = S_MOD_A;
                    end
                end
            end
            S_MOD_A: begin
                if (w_rem_done) begin
                    n_idx   = w_rem_out[IDX_W-1:0];
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            // hit: interval check; miss: claim slot with a phase offset
            S_CMP: begin
                if (w_ram_key != r_addr) begin
                    w_hash_x     = ~r_addr;
                    w_hash_start = 1'b1;
                    n_state      = S_HASH_B;
                end else if (w_age >= {29'd0, w_iv}) begin
                    w_wr.tick_we = 1'b1;
                    w_wr.tick    = r_tick;
                    n_decision   = cgut_pkg::DEC_FULL;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_decision = cgut_pkg::DEC_THROTTLE;
                    n_valid    = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_HASH_B: begin
                if (w_hash_done) begin
                    w_rem_start = 1'b1;
                    if (SLOT_POW2) begin
                        w_rem_dvd = 32'(w_hash_h[IDX_W-1:0]);
                        w_rem_div = DIV_W'(w_iv);
                        n_state   = S_PHASE;
                    end else begin
                        n_state = S_MOD_B;
                    end
                end
            end
            S_MOD_B: begin
                if (w_rem_done) begin
                    w_rem_start = 1'b1;
                    w_rem_dvd   = 32'(w_rem_out);
                    w_rem_div   = DIV_W'(w_iv);
                    n_state     = S_PHASE;
                end
            end
            S_PHASE: begin
                if (w_rem_done) begin
                    w_wr.key_we  = 1'b1;
                    w_wr.key     = r_addr;
                    w_wr.tick_we = 1'b1;
                    w_wr.tick    = r_tick - 32'(w_rem_out);
                    n_decision   = cgut_pkg::DEC_FULL;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_ram_addr = (r_state == S_CLEAR) ? r_clr : r_idx;

    // control and frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_valid       <= 1'b0;
            r_frame_count <= '0;
            r_lfc         <= '0;
            r_frame_tick  <= '0;
            r_ref_ctx     <= '0;
            r_last_roll   <= '0;
            r_crowded     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr         <= n_clr;
            r_valid       <= n_valid;
            r_frame_count <= n_frame_count;
            r_lfc         <= n_lfc;
            r_frame_tick  <= n_frame_tick;
            r_ref_ctx     <= n_ref_ctx;
            r_last_roll   <= n_last_roll;
            r_crowded     <= n_crowded;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_decision <= n_decision;
        if (w_accept) begin
            r_addr    <= i_model_address;
            r_on_main <= i_on_main_thread;
            r_active  <= i_model_active;
            r_upd     <= i_update_requested;
            r_parent  <= i_parent_address;
            r_prot    <= i_is_protected;
            r_ctx     <= i_context_address;
            r_tick    <= i_anim_tick;
            r_last    <= i_model_last_tick;
            r_now     <= i_time_ms;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_engage    <= cgut_pkg::ENGAGE_RST;
            r_cfg_disengage <= cgut_pkg::DISENGAGE_RST;
            r_cfg_gap       <= cgut_pkg::GAP_RST;
            r_cfg_busy      <= cgut_pkg::BUSY_RST;
            r_cfg_dense     <= cgut_pkg::DENSE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cgut_pkg::CFG_ENGAGE:    r_cfg_engage    <= i_cfg_data;
                cgut_pkg::CFG_DISENGAGE: r_cfg_disengage <= i_cfg_data;
                cgut_pkg::CFG_GAP:       r_cfg_gap       <= i_cfg_data;
                cgut_pkg::CFG_BUSY:      r_cfg_busy      <= i_cfg_data;
                cgut_pkg::CFG_DENSE:     r_cfg_dense     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cgut_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_x     (w_hash_x),
        .o_done  (w_hash_done),
        .o_h     (w_hash_h)
    );

    cgut_rem #(
        .DIV_W (DIV_W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (w_rem_dvd),
        .i_divisor  (w_rem_div),
        .o_done     (w_rem_done),
        .o_rem      (w_rem_out)
    );

    cgut_slot_ram #(
        .DEPTH (SLOT_ENTRIES),
        .AW    (IDX_W)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_addr (w_ram_addr),
        .i_wr   (w_wr),
        .o_key  (w_ram_key),
        .o_tick (w_ram_tick)
    );

    // outputs
    assign busy                = (r_state != S_IDLE);
    assign o_valid             = r_valid;
    assign o_decision          = r_decision;
    assign o_crowd_engaged     = r_crowded;
    assign o_frame_crowd       = r_lfc;
    assign o_throttle_interval = w_iv;

endmodule

`default_nettype wire

@@ src/cgut_checker.sv @@
// Port-level checks of the crowd update throttle, bound to its top level.
// Uses cgut_pkg for the decision codes.
`timescale 1ns / 1ps
`default_nettype none

module cgut_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [1:0]  o_decision,
    input wire logic        o_crowd_engaged,
    input wire logic [2:0]  o_throttle_interval
);

    // an accepted transaction holds the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a transaction");

    // the result strobe comes as the block turns free
    a_valid_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // throttling happens only in a crowded scene
    a_throttle_crowded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_decision == cgut_pkg::DEC_THROTTLE)) |-> o_crowd_engaged)
        else $error("throttled result without crowded flag");

    // decision and interval codes stay in range
    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_decision != 2'd3) && (o_throttle_interval >= 3'd2)
                     && (o_throttle_interval <= 3'd4)))
        else $error("result code out of range");

endmodule

bind crowd_graduated_update_throttle cgut_checker u_cgut_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .o_valid             (o_valid),
    .o_decision          (o_decision),
    .o_crowd_engaged     (o_crowd_engaged),
    .o_throttle_interval (o_throttle_interval)
);

`default_nettype wire
